// ===== src/fpr_pkg.sv =====
// fpr_pkg: shared types and constants of the fifo page replacement unit
// no dependencies
`default_nettype none
package fpr_pkg;

	localparam int ADDR_W   = 24;
	localparam int PSIZE_W  = 16;
	localparam int FCNT_W   = 5;
	localparam int STATUS_W = 2;
	localparam int FRAME_W  = 4;
	localparam int EVICT_W  = 8;
	localparam int CFG_IDX_W = 1;

	// restoring division, one quotient bit per step
	localparam int DIV_STEPS = ADDR_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = 16'd1024;
	localparam logic [FCNT_W-1:0]  FRAME_COUNT_RST = 5'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_SIZE   = 1'b0,
		REG_FRAME_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT     = 2'd0,
		ST_LOADED  = 2'd1,
		ST_REPLACE = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  quotient;
		logic [PSIZE_W-1:0] remainder;
	} div_res_t;

endpackage
`default_nettype wire

// ===== src/fpr_ram.sv =====
// fpr_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/fpr_div.sv =====
// fpr_div: sequential restoring divider, 24-bit dividend by 16-bit divisor
// depends on fpr_pkg
`default_nettype none
module fpr_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic [fpr_pkg::ADDR_W-1:0]    dividend,
	input  wire logic [fpr_pkg::PSIZE_W-1:0]   divisor,
	output logic                               done,
	output fpr_pkg::div_res_t                  res
);
	import fpr_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0]    quo_q;
	logic [PSIZE_W-1:0]   rem_q;
	logic [PSIZE_W-1:0]   dvs_q;

	logic [PSIZE_W:0]     shifted;
	logic [PSIZE_W+1:0]   diff;
	logic                 fits;

	always_comb begin
		shifted = {rem_q, quo_q[ADDR_W-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
		fits    = ~diff[PSIZE_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[ADDR_W-2:0], fits};
			rem_q <= fits ? diff[PSIZE_W-1:0] : shifted[PSIZE_W-1:0];
		end
	end

	assign done          = done_q;
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

endmodule
`default_nettype wire

// ===== src/fifo_page_replacement.sv =====
// fifo_page_replacement: top level, address split, resident lookup, fifo replacement
// depends on fpr_pkg, fpr_div, fpr_ram
//
// channel   direction  signals                                          handshake
// command   in         vaddr                                            start & !busy
// result    out        page_number page_offset status frame_number      result_valid
//                      evicted_page evicted_valid                       (one cycle)
// config    in         cfg_index cfg_wdata                              cfg_we
//
// from the accepting edge: 24 divider steps (one quotient bit each), quotient hand-over,
// one range check in S_CHECK with the resident map read; an out of range page returns
// from S_CHECK, a hit or a free-frame load from S_LOOKUP, a replacement from S_COMMIT
// after S_EVICT; busy falls with the result strobe, so the next item can start at the
// edge that ends it; after reset a clearing pass over all MAX_PAGES entries wipes the
// resident map, busy is high; results are shown for one cycle and cannot be stalled
`default_nettype none
module fifo_page_replacement #(
	parameter int MAX_PAGES  = 256,
	parameter int MAX_FRAMES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [fpr_pkg::ADDR_W-1:0]      vaddr,
	input  wire logic                            cfg_we,
	input  wire logic [fpr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fpr_pkg::PSIZE_W-1:0]     cfg_wdata,
	output logic                                 result_valid,
	output logic      [fpr_pkg::ADDR_W-1:0]      page_number,
	output logic      [fpr_pkg::PSIZE_W-1:0]     page_offset,
	output logic      [fpr_pkg::STATUS_W-1:0]    status,
	output logic      [fpr_pkg::FRAME_W-1:0]     frame_number,
	output logic      [fpr_pkg::EVICT_W-1:0]     evicted_page,
	output logic                                 evicted_valid
);
	import fpr_pkg::*;

	localparam int PW  = $clog2(MAX_PAGES);
	localparam int FW  = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
	localparam int FCW = $clog2(MAX_FRAMES + 1);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_DIV    = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_LOOKUP = 7'b0010000,
		S_EVICT  = 7'b0100000,
		S_COMMIT = 7'b1000000
	} state_t;

	state_t               state_q, state_d;
	logic [PSIZE_W-1:0]   page_size_q;
	logic [FCNT_W-1:0]    frame_count_q;
	logic [PW-1:0]        clr_cnt_q;
	logic [FCW-1:0]       filled_q;
	logic [FW-1:0]        oldest_q;
	logic [FW-1:0]        frame_q;
	logic [PW-1:0]        evict_q;
	logic                 result_valid_q;

	logic                 accept;
	logic [PSIZE_W-1:0]   divisor;
	logic                 div_done;
	div_res_t             div_res;

	logic                 res_we;
	logic [PW-1:0]        res_waddr;
	logic [FW:0]          res_wdata;
	logic [FW:0]          res_rdata;
	logic                 fp_we;
	logic [FW-1:0]        fp_waddr;
	logic [PW-1:0]        fp_wdata;
	logic [PW-1:0]        fp_rdata;

	logic [PW-1:0]        page;
	logic                 in_range;
	logic [FCNT_W-1:0]    fc_min;
	logic [FCW-1:0]       n_eff;
	logic                 can_load;
	logic [FW-1:0]        victim;
	logic [FCW-1:0]       nxt;
	logic [FW-1:0]        oldest_d;

	assign accept  = start && state_q == S_IDLE;
	assign busy    = state_q != S_IDLE;
	assign divisor = (page_size_q == '0) ? PSIZE_W'(1) : page_size_q;

	fpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept),
		.dividend (vaddr),
		.divisor  (divisor),
		.done     (div_done),
		.res      (div_res)
	);

	// resident map: valid bit and holding frame per page
	fpr_ram #(.WIDTH(FW + 1), .DEPTH(MAX_PAGES)) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (res_waddr),
		.wdata (res_wdata),
		.raddr (page),
		.rdata (res_rdata)
	);

	// frame table: page held by each frame
	fpr_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES)) u_fp_ram (
		.clk   (clk),
		.we    (fp_we),
		.waddr (fp_waddr),
		.wdata (fp_wdata),
		.raddr (victim),
		.rdata (fp_rdata)
	);

	always_comb begin
		page     = div_res.quotient[PW-1:0];
		in_range = div_res.quotient < ADDR_W'(MAX_PAGES);
		fc_min   = (frame_count_q == '0) ? FCNT_W'(1) : frame_count_q;
		n_eff    = (32'(fc_min) > MAX_FRAMES) ? FCW'(MAX_FRAMES) : FCW'(fc_min);
		can_load = filled_q < n_eff;
		victim   = (FCW'(oldest_q) < n_eff) ? oldest_q : '0;
		nxt      = FCW'(frame_q) + FCW'(1);
		oldest_d = (nxt >= n_eff) ? '0 : nxt[FW-1:0];
	end

	always_comb begin
		state_d   = state_q;
		res_we    = 1'b0;
		res_waddr = page;
		res_wdata = '0;
		fp_we     = 1'b0;
		fp_waddr  = frame_q;
		fp_wdata  = page;
		case (state_q)
			S_CLEAR: begin
				res_we    = 1'b1;
				res_waddr = clr_cnt_q;
				if (clr_cnt_q == PW'(MAX_PAGES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = in_range ? S_LOOKUP : S_IDLE;
			end
			S_LOOKUP: begin
				if (res_rdata[FW]) begin
					state_d = S_IDLE;
				end else if (can_load) begin
					res_we    = 1'b1;
					res_wdata = {1'b1, filled_q[FW-1:0]};
					fp_we     = 1'b1;
					fp_waddr  = filled_q[FW-1:0];
					state_d   = S_IDLE;
				end else begin
					state_d = S_EVICT;
				end
			end
			S_EVICT: begin
				// drop the old page, hand the frame to the new one
				res_we    = 1'b1;
				res_waddr = fp_rdata;
				fp_we     = 1'b1;
				state_d   = S_COMMIT;
			end
			S_COMMIT: begin
				res_we    = 1'b1;
				res_wdata = {1'b1, frame_q};
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_cnt_q      <= '0;
			page_size_q    <= PAGE_SIZE_RST;
			frame_count_q  <= FRAME_COUNT_RST;
			filled_q       <= '0;
			oldest_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= 1'b0;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + PW'(1);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PAGE_SIZE:   page_size_q   <= cfg_wdata;
					REG_FRAME_COUNT: frame_count_q <= cfg_wdata[FCNT_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_CHECK && !in_range) begin
				result_valid_q <= 1'b1;
			end
			if (state_q == S_LOOKUP && (res_rdata[FW] || can_load)) begin
				result_valid_q <= 1'b1;
			end
			if (state_q == S_LOOKUP && !res_rdata[FW] && can_load) begin
				filled_q <= filled_q + FCW'(1);
			end
			if (state_q == S_COMMIT) begin
				oldest_q       <= oldest_d;
				result_valid_q <= 1'b1;
			end
		end
	end

	// transaction payload
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			page_number   <= div_res.quotient;
			page_offset   <= div_res.remainder;
			status        <= ST_RANGE;
			frame_number  <= '0;
			evicted_page  <= '0;
			evicted_valid <= 1'b0;
		end
		if (state_q == S_LOOKUP) begin
			frame_q <= victim;
			if (res_rdata[FW]) begin
				status       <= ST_HIT;
				frame_number <= FRAME_W'(res_rdata[FW-1:0]);
			end else if (can_load) begin
				status       <= ST_LOADED;
				frame_number <= FRAME_W'(filled_q);
			end
		end
		if (state_q == S_EVICT) begin
			evict_q <= fp_rdata;
		end
		if (state_q == S_COMMIT) begin
			status        <= ST_REPLACE;
			frame_number  <= FRAME_W'(frame_q);
			evicted_page  <= EVICT_W'(evict_q);
			evicted_valid <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FCW'(MAX_FRAMES))
		else $error("fill count beyond frame capacity");

	a_evict_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && evicted_valid |-> status == ST_REPLACE)
		else $error("eviction reported without replacement status");

endmodule
`default_nettype wire

// ===== sim/fifo_page_replacement_tb.sv =====
// fifo_page_replacement_tb: self-checking testbench for the fifo page replacement unit
// drives a directed table, then random streams; checks listed rows as given, the rest
// by an internal page table predictor; depends on fpr_pkg and fifo_page_replacement
`timescale 1ns / 100ps
`default_nettype none
module fifo_page_replacement_tb;
	import fpr_pkg::*;

	localparam int NUM_PAGES     = 256;
	localparam int NUM_FRAMES    = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASE_ITEMS   = 150;
	localparam int NUM_PHASES    = 8;

	typedef struct packed {
		logic [ADDR_W-1:0]  page_number;
		logic [PSIZE_W-1:0] page_offset;
		status_t            status;
		logic [FRAME_W-1:0] frame_number;
		logic [EVICT_W-1:0] evicted_page;
		logic               evicted_valid;
	} translation_t;

	typedef struct {
		bit                 is_cfg;
		cfg_reg_t           reg_idx;
		logic [PSIZE_W-1:0] wdata;
		logic [ADDR_W-1:0]  addr;
		bit                 known;
		translation_t       res;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [ADDR_W-1:0]    vaddr = '0;
	logic                 cfg_we = 1'b0;
	cfg_reg_t             cfg_index = REG_PAGE_SIZE;
	logic [PSIZE_W-1:0]   cfg_wdata = '0;
	logic                 result_valid;
	logic [ADDR_W-1:0]    page_number;
	logic [PSIZE_W-1:0]   page_offset;
	logic [STATUS_W-1:0]  status;
	logic [FRAME_W-1:0]   frame_number;
	logic [EVICT_W-1:0]   evicted_page;
	logic                 evicted_valid;

	// predictor state
	bit                   resident_pages [NUM_PAGES];
	logic [EVICT_W-1:0]   frame_owner [NUM_FRAMES];
	int unsigned          filled_frames = 0;
	int unsigned          replace_ptr = 0;
	int unsigned          page_size_reg = 32'(PAGE_SIZE_RST);
	int unsigned          frame_count_reg = 32'(FRAME_COUNT_RST);

	translation_t         expected_translations [$];
	stim_row_t            directed_rows [$];
	int                   mismatch_count = 0;
	int                   cycle_count = 0;

	fifo_page_replacement i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.vaddr           (vaddr),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.result_valid    (result_valid),
		.page_number     (page_number),
		.page_offset     (page_offset),
		.status          (status),
		.frame_number    (frame_number),
		.evicted_page    (evicted_page),
		.evicted_valid   (evicted_valid)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned frames_active();
		if (frame_count_reg == 0)
			return 1;
		if (frame_count_reg > NUM_FRAMES)
			return NUM_FRAMES;
		return frame_count_reg;
	endfunction

	function automatic translation_t translate_address(input logic [ADDR_W-1:0] a);
		translation_t t;
		int unsigned  divisor;
		int unsigned  av;
		int unsigned  pg;
		int unsigned  n;
		int unsigned  fr;
		divisor = (page_size_reg == 0) ? 1 : page_size_reg;
		av = 32'(a);
		pg = av / divisor;
		n = frames_active();
		t.page_number = ADDR_W'(pg);
		t.page_offset = PSIZE_W'(av % divisor);
		t.frame_number = '0;
		t.evicted_page = '0;
		t.evicted_valid = 1'b0;
		if (pg >= NUM_PAGES) begin
			t.status = ST_RANGE;
		end else if (resident_pages[pg]) begin
			t.status = ST_HIT;
			for (int f = int'(filled_frames) - 1; f >= 0; f--)
				if (f < NUM_FRAMES && frame_owner[f] == pg)
					t.frame_number = FRAME_W'(f);
		end else if (filled_frames < n) begin
			t.status = ST_LOADED;
			t.frame_number = FRAME_W'(filled_frames);
			frame_owner[filled_frames] = EVICT_W'(pg);
			resident_pages[pg] = 1'b1;
			filled_frames++;
		end else begin
			t.status = ST_REPLACE;
			fr = (replace_ptr < n) ? replace_ptr : 0;
			t.frame_number = FRAME_W'(fr);
			t.evicted_page = frame_owner[fr];
			t.evicted_valid = 1'b1;
			resident_pages[frame_owner[fr]] = 1'b0;
			frame_owner[fr] = EVICT_W'(pg);
			resident_pages[pg] = 1'b1;
			replace_ptr = (fr + 1 >= n) ? 0 : fr + 1;
		end
		return t;
	endfunction

	task automatic add_item(input logic [ADDR_W-1:0] a);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.reg_idx = REG_PAGE_SIZE;
		r.wdata = '0;
		r.addr = a;
		r.known = 1'b0;
		r.res = '0;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic add_known(input logic [ADDR_W-1:0] a, input int unsigned pn,
			input int unsigned po, input status_t st, input int unsigned fr,
			input int unsigned ev, input bit evv);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.reg_idx = REG_PAGE_SIZE;
		r.wdata = '0;
		r.addr = a;
		r.known = 1'b1;
		r.res.page_number = ADDR_W'(pn);
		r.res.page_offset = PSIZE_W'(po);
		r.res.status = st;
		r.res.frame_number = FRAME_W'(fr);
		r.res.evicted_page = EVICT_W'(ev);
		r.res.evicted_valid = evv;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic add_cfg(input cfg_reg_t idx, input logic [PSIZE_W-1:0] d);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.wdata = d;
		r.addr = '0;
		r.known = 1'b0;
		r.res = '0;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic wait_idle();
		while (expected_translations.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [PSIZE_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PAGE_SIZE)
			page_size_reg = 32'(d);
		else
			frame_count_reg = 32'(d[FCNT_W-1:0]);
		@(posedge clk);
	endtask

	// one command transaction; start stays high when another item follows
	task automatic send_address(input logic [ADDR_W-1:0] a, input int idle_pct,
			input bit last, input bit known, input translation_t typed);
		translation_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		vaddr <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = translate_address(a);
		expected_translations.insert(expected_translations.size(),
			known ? typed : predicted);
		if (last)
			start <= 1'b0;
	endtask

	task automatic random_address(input int unsigned ps, input int base, input int ws,
			output logic [ADDR_W-1:0] a);
		int          r;
		int unsigned pg;
		int unsigned off;
		longint      full;
		r = $urandom_range(99);
		if (r < 10) begin
			a = ADDR_W'($urandom);
		end else begin
			if (r < 18)
				pg = $urandom_range(NUM_PAGES - 1);
			else if (r < 23)
				pg = $urandom_range(NUM_PAGES + 1, NUM_PAGES - 6);
			else
				pg = base + $urandom_range(ws - 1);
			off = $urandom_range(ps - 1);
			full = longint'(pg) * ps + off;
			a = (full > 24'hFFFFFF) ? 24'hFFFFFF : full[ADDR_W-1:0];
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		translation_t exp_t;
		if (arst_n && result_valid) begin
			if (expected_translations.size() == 0) begin
				$error("result with no transaction outstanding");
				mismatch_count++;
			end else begin
				exp_t = expected_translations.pop_front();
				check_field("page_number", 32'(exp_t.page_number), 32'(page_number));
				check_field("page_offset", 32'(exp_t.page_offset), 32'(page_offset));
				check_field("status", 32'(exp_t.status), 32'(status));
				check_field("frame_number", 32'(exp_t.frame_number), 32'(frame_number));
				check_field("evicted_page", 32'(exp_t.evicted_page), 32'(evicted_page));
				check_field("evicted_valid", 32'(exp_t.evicted_valid),
					32'(evicted_valid));
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("fifo_page_replacement_tb: errors");
		$finish;
	end

	initial begin : stimulus
		int                 phase_psize [NUM_PHASES];
		int                 phase_fcount [NUM_PHASES];
		int                 item_idx;
		int                 idle_pct;
		int unsigned        ps;
		int                 n;
		int                 ws;
		int                 base;
		bit                 last;
		logic [ADDR_W-1:0]  a;

		phase_psize = '{1024, 65535, 1, 256, 0, 4096, 3, 65534};
		phase_fcount = '{4, 16, 1, 7, 0, 31, 2, 17};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: page size 1024, four frames
		add_known(24'd0, 0, 0, ST_LOADED, 0, 0, 0);
		add_known(24'hFFFFFF, 16383, 1023, ST_RANGE, 0, 0, 0);
		add_known(24'd1023, 0, 1023, ST_HIT, 0, 0, 0);
		add_known(24'd261125, 255, 5, ST_LOADED, 1, 0, 0);
		add_known(24'd262144, 256, 0, ST_RANGE, 0, 0, 0);
		add_known(24'd2048, 2, 0, ST_LOADED, 2, 0, 0);
		add_known(24'd3079, 3, 7, ST_LOADED, 3, 0, 0);
		add_known(24'd4096, 4, 0, ST_REPLACE, 0, 0, 1);
		add_known(24'd0, 0, 0, ST_REPLACE, 1, 255, 1);
		add_known(24'd261120, 255, 0, ST_REPLACE, 2, 2, 1);
		// zero page size and zero frame count, frames above the count still hit
		add_cfg(REG_PAGE_SIZE, 16'd0);
		add_cfg(REG_FRAME_COUNT, 16'd0);
		add_known(24'd255, 255, 0, ST_HIT, 2, 0, 0);
		add_known(24'd256, 256, 0, ST_RANGE, 0, 0, 0);
		add_known(24'd7, 7, 0, ST_REPLACE, 0, 4, 1);
		add_known(24'd3, 3, 0, ST_HIT, 3, 0, 0);
		// largest page size, frame count above the frame limit
		add_cfg(REG_PAGE_SIZE, 16'd65535);
		add_cfg(REG_FRAME_COUNT, 16'd31);
		add_known(24'hFFFFFF, 256, 255, ST_RANGE, 0, 0, 0);
		add_known(24'd16776959, 255, 65534, ST_HIT, 2, 0, 0);
		add_known(24'd6553500, 100, 0, ST_LOADED, 4, 0, 0);
		// upper data bits are dropped for the frame count
		add_cfg(REG_PAGE_SIZE, 16'd1);
		add_cfg(REG_FRAME_COUNT, 16'h0025);
		add_item(24'd200);
		add_item(24'd1);
		add_item(24'd4);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				write_register(directed_rows[i].reg_idx, directed_rows[i].wdata);
			end else begin
				last = (i == directed_rows.size() - 1) || directed_rows[i + 1].is_cfg;
				send_address(directed_rows[i].addr, 28, last, directed_rows[i].known,
					directed_rows[i].res);
			end
		end

		item_idx = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_register(REG_PAGE_SIZE, PSIZE_W'(phase_psize[p]));
			write_register(REG_FRAME_COUNT, PSIZE_W'(phase_fcount[p]));
			ps = (page_size_reg == 0) ? 1 : page_size_reg;
			n = frames_active();
			ws = $urandom_range(2 * n + 2, (n > 1) ? n - 1 : 1);
			base = $urandom_range(NUM_PAGES - ws);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				idle_pct = (item_idx < 400) ? 28 : (item_idx < 800) ? 81 : 0;
				random_address(ps, base, ws, a);
				send_address(a, idle_pct, k == PHASE_ITEMS - 1, 1'b0, '0);
				item_idx++;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_translations.size() != 0) begin
			$error("%0d transactions without a result", expected_translations.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("fifo_page_replacement_tb: clean");
		else
			$display("fifo_page_replacement_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
